// ===== design/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// shared types and constants of the sph density and factor block
// ----------------------------------------------------------------------------
package sdf_pkg;

  // classified neighbor item, as queued between front and back
  typedef struct packed {
    logic [23:0] ax;
    logic        px;
    logic [23:0] ay;
    logic        py;
    logic [23:0] mass;
    logic        skip;
    logic        last;
  } sdf_item_t;

  // configuration registers
  typedef struct packed {
    logic [23:0] support_length;
    logic [23:0] inv_support_length;
    logic [31:0] kernel_norm;
    logic [31:0] base_density;
    logic [47:0] factor_floor;
  } sdf_cfg_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_SUPPORT_LENGTH     = 3'd0,
    REG_INV_SUPPORT_LENGTH = 3'd1,
    REG_KERNEL_NORM        = 3'd2,
    REG_BASE_DENSITY       = 3'd3,
    REG_FACTOR_FLOOR       = 3'd4
  } sdf_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_ADD,
    ST_SQRT,
    ST_Q_MUL,
    ST_Q_CHK,
    ST_P2,
    ST_P3,
    ST_W,
    ST_D,
    ST_KG,
    ST_DW,
    ST_DIV,
    ST_GM,
    ST_MG,
    ST_SQ_START,
    ST_SQ_LO,
    ST_SQ_HI,
    ST_SQ_DONE,
    ST_ACC,
    ST_END,
    ST_FDIV,
    ST_EMIT
  } sdf_state_e;

  // what the shared square path is working on
  typedef enum logic [1:0] {
    PH_GX,
    PH_GY,
    PH_FX,
    PH_FY
  } sdf_phase_e;

  localparam logic [23:0] RST_SUPPORT_LENGTH     = 24'd19661;
  localparam logic [23:0] RST_INV_SUPPORT_LENGTH = 24'd218453;
  localparam logic [31:0] RST_KERNEL_NORM        = 32'd1324500;
  localparam logic [31:0] RST_BASE_DENSITY       = 32'd256000;
  localparam logic [47:0] RST_FACTOR_FLOOR       = 48'd1099512;

  localparam int unsigned DIV_W = 64;

endpackage

// ===== design/sdf_front.sv =====
// ----------------------------------------------------------------------------
// sdf_front
// takes neighbor items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [23:0] offset_x_i,
  input  logic signed [23:0] offset_y_i,
  input  logic        [23:0] neighbor_mass_i,
  input  logic               skip_self_i,
  input  logic               last_neighbor_i,
  output logic               item_valid_o,
  output sdf_item_t          item_o,
  input  logic               item_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sdf_item_t             mem_q [Depth];
  logic      [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic      [CntW-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;
  sdf_item_t             cls;

  // magnitudes and signs of the offset
  always_comb begin
    cls.ax   = offset_x_i[23] ? 24'(-offset_x_i) : offset_x_i;
    cls.px   = !offset_x_i[23] && (offset_x_i != 24'sd0);
    cls.ay   = offset_y_i[23] ? 24'(-offset_y_i) : offset_y_i;
    cls.py   = !offset_y_i[23] && (offset_y_i != 24'sd0);
    cls.mass = neighbor_mass_i;
    cls.skip = skip_self_i;
    cls.last = last_neighbor_i;
  end

  assign full_o       = (cnt_q == FullCnt);
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cls;
    end
  end

endmodule

// ===== design/sdf_div.sv =====
// ----------------------------------------------------------------------------
// sdf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sdf_div import sdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DIV_W);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DIV_W:0]   rem_q, rem_sh, rem_d;
  logic [DIV_W-1:0] quo_q, den_q;
  logic             qbit;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});
  assign rem_d  = qbit ? rem_sh - {1'b0, den_q} : rem_sh;
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], qbit};
    end
  end

endmodule

// ===== design/sdf_back.sv =====
// ----------------------------------------------------------------------------
// sdf_back
// kernel sequencer: one shared multiplier, square root, divider, accumulators
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sdf_cfg_t    cfg_i,
  input  logic        item_valid_i,
  input  sdf_item_t   item_i,
  output logic        item_pop_o,
  output logic        res_valid_o,
  input  logic        res_pop_i,
  output logic [31:0] res_density_o,
  output logic [47:0] res_factor_o
);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [47:0] clamp_sum(input logic signed [49:0] s);
    logic signed [47:0] r;
    if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
      r = s[47:0];
    end else if (s[49]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  sdf_state_e         state_q, state_d;
  sdf_phase_e         phase_q;
  sdf_item_t          item_q;
  logic               open_q;
  logic [31:0]        ds_q;
  logic signed [47:0] gsx_q, gsy_q;
  logic [63:0]        gss_q;
  logic [47:0]        x2_q, v_q, rt_q, bit_q;
  logic [23:0]        r_q;
  logic [16:0]        p_q, p2_q;
  logic               half_q;  // q branch is latched with the p value
  logic [19:0]        g_q;
  logic [43:0]        dw_q;
  logic [47:0]        mg_q, mgx_q, lo_q;
  logic [63:0]        sq_q, sqx_q;
  logic [47:0]        fac_q;
  logic [71:0]        prod_q;
  logic               res_valid_q;
  logic [31:0]        res_den_q;
  logic [47:0]        res_fac_q;

  logic [47:0]        mul_a;
  logic [23:0]        mul_b;
  logic               div_start;
  logic [DIV_W-1:0]   div_num, div_den, div_quot;
  logic               div_done;

  // datapath views of the product
  logic [31:0]        q_w;
  logic               in_range, q_half;
  logic [16:0]        p_next, p3_w, f_next;
  logic [19:0]        g_next;
  logic [41:0]        ds_sum;
  logic [44:0]        gm_w;
  logic [39:0]        gm_sat;
  logic [63:0]        sq_full, den_w;
  logic [47:0]        rt_bit;
  logic signed [48:0] mx, my;
  logic [47:0]        gsx_mag, gsy_mag;

  assign q_w      = prod_q[47:16];
  assign in_range = (r_q <= cfg_i.support_length) && (q_w <= 32'd65536);
  assign q_half   = (q_w <= 32'd32768);
  assign p_next   = q_half ? q_w[16:0] : 17'h10000 - q_w[16:0];
  assign p3_w     = prod_q[32:16];

  always_comb begin
    if (half_q) begin
      f_next = 17'(20'd65536 - 20'd6 * ({3'b0, p2_q} - {3'b0, p3_w}));
    end else begin
      f_next = {p3_w[15:0], 1'b0};
    end
  end

  assign g_next  = half_q ? 20'd12 * {3'b0, p_q} - 20'd18 * {3'b0, p2_q}
                          : 20'd6 * {3'b0, p2_q};
  assign ds_sum  = {10'd0, ds_q} + {1'b0, prod_q[56:16]};
  assign gm_w    = prod_q[60:16];
  assign gm_sat  = (|gm_w[44:40]) ? '1 : gm_w[39:0];
  assign sq_full = {16'd0, lo_q} + {prod_q[47:0], 16'd0};
  assign den_w   = sat_add(sat_add(sqx_q, sq_q), gss_q);
  assign rt_bit  = rt_q + bit_q;
  assign mx      = item_q.px ? -$signed({1'b0, mgx_q}) : $signed({1'b0, mgx_q});
  assign my      = item_q.py ? -$signed({1'b0, mg_q}) : $signed({1'b0, mg_q});
  assign gsx_mag = gsx_q[47] ? 48'(-gsx_q) : gsx_q;
  assign gsy_mag = gsy_q[47] ? 48'(-gsy_q) : gsy_q;

  sdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.skip ? ST_END : ST_SQ_X;
        end
      end
      ST_SQ_X:     state_d = ST_SQ_Y;
      ST_SQ_Y:     state_d = ST_SQ_ADD;
      ST_SQ_ADD:   state_d = ST_SQRT;
      ST_SQRT:     state_d = (bit_q == 48'd1) ? ST_Q_MUL : ST_SQRT;
      ST_Q_MUL:    state_d = ST_Q_CHK;
      ST_Q_CHK:    state_d = in_range ? ST_P2 : ST_END;
      ST_P2:       state_d = ST_P3;
      ST_P3:       state_d = ST_W;
      ST_W:        state_d = ST_D;
      ST_D:        state_d = (r_q == 24'd0) ? ST_END : ST_KG;
      ST_KG:       state_d = ST_DW;
      ST_DW:       state_d = ST_DIV;
      ST_DIV:      state_d = div_done ? ST_GM : ST_DIV;
      ST_GM:       state_d = ST_MG;
      ST_MG:       state_d = ST_SQ_START;
      ST_SQ_START: state_d = (|mg_q[47:32]) ? ST_SQ_DONE : ST_SQ_LO;
      ST_SQ_LO:    state_d = ST_SQ_HI;
      ST_SQ_HI:    state_d = ST_SQ_DONE;
      ST_SQ_DONE: begin
        case (phase_q)
          PH_GX:   state_d = ST_DIV;
          PH_GY:   state_d = ST_ACC;
          PH_FX:   state_d = ST_SQ_START;
          PH_FY:   state_d = (den_w == 64'd0) ? ST_EMIT : ST_FDIV;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ACC:      state_d = ST_END;
      ST_END:      state_d = item_q.last ? ST_SQ_START : ST_IDLE;
      ST_FDIV:     state_d = div_done ? ST_EMIT : ST_FDIV;
      ST_EMIT:     state_d = res_valid_q ? ST_EMIT : ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    item_pop_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = {40'd0, r_q};
    case (state_q)
      ST_IDLE:  item_pop_o = item_valid_i;
      ST_SQ_X: begin
        mul_a = {24'd0, item_q.ax};
        mul_b = item_q.ax;
      end
      ST_SQ_Y: begin
        mul_a = {24'd0, item_q.ay};
        mul_b = item_q.ay;
      end
      ST_Q_MUL: begin
        mul_a = {24'd0, rt_q[23:0]};
        mul_b = cfg_i.inv_support_length;
      end
      ST_Q_CHK: begin
        mul_a = {31'd0, p_next};
        mul_b = {7'd0, p_next};
      end
      ST_P2: begin
        mul_a = {31'd0, prod_q[32:16]};
        mul_b = {7'd0, p_q};
      end
      ST_P3: begin
        mul_a = {16'd0, cfg_i.kernel_norm};
        mul_b = {7'd0, f_next};
      end
      ST_W: begin
        mul_a = {15'd0, prod_q[48:16]};
        mul_b = item_q.mass;
      end
      ST_D: begin
        mul_a = {16'd0, cfg_i.kernel_norm};
        mul_b = {4'd0, g_q};
      end
      ST_KG: begin
        mul_a = {12'd0, prod_q[51:16]};
        mul_b = cfg_i.inv_support_length;
      end
      ST_DW: begin
        div_start = 1'b1;
        div_num   = {24'd0, item_q.ax, 16'd0};
      end
      ST_DIV: begin
        mul_a = {4'd0, dw_q};
        mul_b = {7'd0, div_quot[16:0]};
      end
      ST_GM: begin
        mul_a = {8'd0, gm_sat};
        mul_b = item_q.mass;
      end
      ST_SQ_START: begin
        mul_a = {16'd0, mg_q[31:0]};
        mul_b = {8'd0, mg_q[15:0]};
      end
      ST_SQ_LO: begin
        mul_a = {16'd0, mg_q[31:0]};
        mul_b = {8'd0, mg_q[31:16]};
      end
      ST_SQ_DONE: begin
        if (phase_q == PH_GX) begin
          div_start = 1'b1;
          div_num   = {24'd0, item_q.ay, 16'd0};
        end else if (phase_q == PH_FY && den_w != 64'd0) begin
          div_start = 1'b1;
          div_num   = 64'd1 << 56;
          div_den   = den_w;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_GX;
      open_q      <= 1'b0;
      res_valid_q <= 1'b0;
      ds_q        <= '0;
      gsx_q       <= '0;
      gsy_q       <= '0;
      gss_q       <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            phase_q <= PH_GX;
            open_q  <= 1'b1;
            if (!open_q) begin
              ds_q <= cfg_i.base_density;
            end
          end
        end
        ST_D:    ds_q <= (|ds_sum[41:32]) ? '1 : ds_sum[31:0];
        ST_SQ_DONE: begin
          case (phase_q)
            PH_GX:   phase_q <= PH_GY;
            PH_FX:   phase_q <= PH_FY;
            default: ;
          endcase
        end
        ST_ACC: begin
          gsx_q <= clamp_sum({{1{mx[48]}}, mx} + {{2{gsx_q[47]}}, gsx_q});
          gsy_q <= clamp_sum({{1{my[48]}}, my} + {{2{gsy_q[47]}}, gsy_q});
          gss_q <= sat_add(gss_q, sat_add(sqx_q, sq_q));
        end
        ST_END:  phase_q <= PH_FX;
        ST_EMIT: begin
          if (!res_valid_q) begin
            res_valid_q <= 1'b1;
            open_q      <= 1'b0;
            gsx_q       <= '0;
            gsy_q       <= '0;
            gss_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= 72'(mul_a) * 72'(mul_b);
    case (state_q)
      ST_IDLE:   if (item_valid_i) item_q <= item_i;
      ST_SQ_Y:   x2_q <= prod_q[47:0];
      ST_SQ_ADD: begin
        v_q   <= x2_q + prod_q[47:0];
        rt_q  <= '0;
        bit_q <= 48'd1 << 46;
      end
      ST_SQRT: begin
        if (v_q >= rt_bit) begin
          v_q  <= v_q - rt_bit;
          rt_q <= (rt_q >> 1) + bit_q;
        end else begin
          rt_q <= rt_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_Q_MUL:  r_q <= rt_q[23:0];
      ST_Q_CHK: begin
        p_q    <= p_next;
        half_q <= q_half;
      end
      ST_P2:     p2_q <= prod_q[32:16];
      ST_P3:     g_q <= g_next;
      ST_DW:     dw_q <= prod_q[59:16];
      ST_MG:     mg_q <= prod_q[63:16];
      ST_SQ_START: if (|mg_q[47:32]) sq_q <= '1;
      ST_SQ_LO:  lo_q <= prod_q[47:0];
      ST_SQ_HI:  sq_q <= sq_full;
      ST_SQ_DONE: begin
        case (phase_q)
          PH_GX: begin
            mgx_q <= mg_q;
            sqx_q <= sq_q;
          end
          PH_FX: begin
            sqx_q <= sq_q;
            mg_q  <= gsy_mag;
          end
          PH_FY:   fac_q <= '1;
          default: ;
        endcase
      end
      ST_END:    mg_q <= gsx_mag;
      ST_FDIV: begin
        if (div_done) begin
          fac_q <= (|div_quot[63:48]) ? '1 : div_quot[47:0];
        end
      end
      ST_EMIT: begin
        if (!res_valid_q) begin
          res_den_q <= ds_q;
          res_fac_q <= (fac_q < cfg_i.factor_floor) ? cfg_i.factor_floor : fac_q;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o   = res_valid_q;
  assign res_density_o = res_den_q;
  assign res_factor_o  = res_fac_q;

endmodule

// ===== design/sph_density_and_factor.sv =====
// ----------------------------------------------------------------------------
// sph_density_and_factor
// neighbor accumulator for sph density and the dfsph stiffness factor
// ----------------------------------------------------------------------------
// Each item is one neighbor of the current particle; the item flagged last
// yields one result (density, stiffness factor) and starts a new particle.
// A neighbor inside the kernel support runs through a 24-step square root
// for the distance, two 64-step divider runs for the direction cosines,
// and the kernel and gradient steps on the one shared 48x24 multiplier.
// An item outside the support ends after the range check, a self item goes
// straight to the end state. A last item adds the factor work, mostly the
// 64-step division. The front queue holds QueueDepth items so that the
// sender can keep pushing while the back end works, and one result
// register lets the next particle start before its result is taken.
// ----------------------------------------------------------------------------
module sph_density_and_factor import sdf_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // neighbor items
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] offset_x_i,
  input  logic signed [23:0] offset_y_i,
  input  logic        [23:0] neighbor_mass_i,
  input  logic               skip_self_i,
  input  logic               last_neighbor_i,
  // results
  output logic               empty,
  input  logic               pop,
  output logic        [31:0] density_o,
  output logic        [47:0] stiffness_factor_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [5:0]  paddr,
  input  logic        [63:0] pwdata,
  output logic        [63:0] prdata,
  output logic               pready
);

  sdf_cfg_t   cfg_q;
  sdf_item_t  item;
  logic       item_valid, item_pop;
  logic       res_valid;
  logic [2:0] reg_idx;
  logic       cfg_we;

  // register file, one register every 8 bytes
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.support_length     <= RST_SUPPORT_LENGTH;
      cfg_q.inv_support_length <= RST_INV_SUPPORT_LENGTH;
      cfg_q.kernel_norm        <= RST_KERNEL_NORM;
      cfg_q.base_density       <= RST_BASE_DENSITY;
      cfg_q.factor_floor       <= RST_FACTOR_FLOOR;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SUPPORT_LENGTH:     cfg_q.support_length     <= pwdata[23:0];
        REG_INV_SUPPORT_LENGTH: cfg_q.inv_support_length <= pwdata[23:0];
        REG_KERNEL_NORM:        cfg_q.kernel_norm        <= pwdata[31:0];
        REG_BASE_DENSITY:       cfg_q.base_density       <= pwdata[31:0];
        REG_FACTOR_FLOOR:       cfg_q.factor_floor       <= pwdata[47:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SUPPORT_LENGTH:     prdata = {40'd0, cfg_q.support_length};
      REG_INV_SUPPORT_LENGTH: prdata = {40'd0, cfg_q.inv_support_length};
      REG_KERNEL_NORM:        prdata = {32'd0, cfg_q.kernel_norm};
      REG_BASE_DENSITY:       prdata = {32'd0, cfg_q.base_density};
      REG_FACTOR_FLOOR:       prdata = {16'd0, cfg_q.factor_floor};
      default:                prdata = '0;
    endcase
  end

  // front: classify offsets into magnitude and sign, queue the item
  sdf_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .offset_x_i     (offset_x_i),
    .offset_y_i     (offset_y_i),
    .neighbor_mass_i(neighbor_mass_i),
    .skip_self_i    (skip_self_i),
    .last_neighbor_i(last_neighbor_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  // back: kernel, gradient, accumulation and factor division
  sdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_density_o(density_o),
    .res_factor_o (stiffness_factor_o)
  );

  assign empty = !res_valid;

  // back end never takes an item from an empty queue
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back end popped an empty queue");

  // a waiting result respects the factor floor unless the floor is raised while it waits
  a_factor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (stiffness_factor_o >= cfg_q.factor_floor))
    else $error("factor below floor");

  // the single result register cannot refill in the cycle it is taken
  a_result_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |=> empty)
    else $error("result register refilled while being taken");

endmodule
